// File: rtl/mbld_pkg.sv
// Package for the message batch limit decider.
// Holds the configuration struct, the queued item struct, action codes and register indexes.
// Used by every module of the block; depends on nothing.
package mbld_pkg;

    localparam int TIME_W  = 48;
    localparam int CNT_W   = 32;
    localparam int CFG_IDX_W = 3;

    // Batching actions
    localparam logic [1:0] ACT_LEAVE_MSG_RETURN_BATCH = 2'd0;
    localparam logic [1:0] ACT_RETURN_BATCH_TAKE_MSG  = 2'd1;
    localparam logic [1:0] ACT_TAKE_MSG_RETURN_BATCH  = 2'd2;
    localparam logic [1:0] ACT_TAKE_MSG_KEEP_BATCH    = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TIME_LIMIT_ENABLE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIME_LIMIT         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT_LIMIT_ENABLE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT_LIMIT        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_LIMIT_ENABLE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_LIMIT         = 3'd5;

    localparam logic [TIME_W-1:0] TIME_ALL_ONES = {TIME_W{1'b1}};
    localparam logic [CNT_W-1:0]  CNT_MAX       = {CNT_W{1'b1}};

    typedef struct packed {
        logic              time_en;
        logic [CNT_W-1:0]  time_limit;
        logic              count_en;
        logic [CNT_W-1:0]  count_limit;
        logic              size_en;
        logic [CNT_W-1:0]  size_limit;
    } cfg_t;

    // One classified message as it travels from front to back
    typedef struct packed {
        logic [TIME_W-1:0] now_time;
        logic [TIME_W-1:0] msg_time;
        logic [CNT_W-1:0]  body_bytes;
        logic [TIME_W-1:0] msg_deadline;  // msg_time + time_limit, wrapped
        logic              oversize;      // byte limit on and body alone reaches it
        logic              msg_aged;      // time limit on and message already past its age
    } item_t;

endpackage

// File: rtl/mbld_front.sv
// Front stage: accepts messages and classifies them against the limits.
// Depends on mbld_pkg; feeds mbld_queue.
module mbld_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mbld_pkg::cfg_t       cfg,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [47:0]          now_time,
    input  logic [47:0]          msg_time,
    input  logic [31:0]          body_bytes,
    output logic                 item_valid,
    output mbld_pkg::item_t      item,
    input  logic                 queue_full
);
    import mbld_pkg::*;

    logic  front_valid_reg, front_valid_next;
    item_t front_item_reg;
    item_t item_next;
    logic  accept;
    logic  push;

    // Classification of the arriving message
    always_comb
    begin
        item_next.now_time     = now_time;
        item_next.msg_time     = msg_time;
        item_next.body_bytes   = body_bytes;
        item_next.msg_deadline = msg_time + {{(TIME_W-CNT_W){1'b0}}, cfg.time_limit};
        item_next.oversize     = cfg.size_en && (body_bytes >= cfg.size_limit);
        item_next.msg_aged     = cfg.time_en && (now_time >= item_next.msg_deadline);
    end

    assign push     = front_valid_reg && !queue_full;
    assign in_stall = front_valid_reg && queue_full;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        front_valid_next = front_valid_reg;
        if (accept)
            front_valid_next = 1'b1;
        else if (push)
            front_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            front_valid_reg <= 1'b0;
        else
            front_valid_reg <= front_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            front_item_reg <= item_next;
    end

    assign item_valid = front_valid_reg;
    assign item       = front_item_reg;

endmodule

// File: rtl/mbld_queue.sv
// Two-entry queue between the front stage and the back stage.
// Depends on mbld_pkg for the item type.
module mbld_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    input  mbld_pkg::item_t  push_item,
    output logic             full,
    output logic             head_valid,
    output mbld_pkg::item_t  head_item,
    input  logic             pop
);
    import mbld_pkg::*;

    localparam int DEPTH = 2;

    item_t       entry_reg [DEPTH];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        do_push;
    logic        do_pop;

    assign full       = (count_reg == 2'(DEPTH));
    assign head_valid = (count_reg != 2'd0);
    assign head_item  = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && !full;
    assign do_pop     = pop && head_valid;

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 2'd1;
        else if (!do_push && do_pop)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

endmodule

// File: rtl/mbld_back.sv
// Back stage: holds the open batch, decides the action and registers the result.
// Depends on mbld_pkg; drains mbld_queue.
module mbld_back (
    input  logic             clk,
    input  logic             rst_n,
    input  mbld_pkg::cfg_t   cfg,
    input  logic             head_valid,
    input  mbld_pkg::item_t  head_item,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [1:0]       action,
    output logic             deadline_valid,
    output logic [47:0]      deadline
);
    import mbld_pkg::*;

    // Batch state
    logic [TIME_W-1:0] earliest_reg, earliest_next;
    logic [CNT_W-1:0]  msgs_reg, msgs_next;
    logic [CNT_W-1:0]  bytes_reg, bytes_next;

    // Result register
    logic              out_valid_reg;
    logic [1:0]        action_reg, action_next;
    logic              dl_valid_reg, dl_valid_next;
    logic [TIME_W-1:0] deadline_reg, deadline_next;

    logic              none_enabled;
    logic [CNT_W:0]    byte_sum;
    logic              byte_overflow;
    logic              count_one;
    logic [TIME_W-1:0] add_earliest;
    logic [CNT_W-1:0]  add_msgs;
    logic [CNT_W-1:0]  add_bytes;
    logic [TIME_W-1:0] add_deadline;
    logic [TIME_W-1:0] old_deadline;
    logic              limit_reached;
    logic [TIME_W-1:0] tl_ext;

    assign pop    = head_valid && (!out_valid_reg || !out_stall);
    assign tl_ext = {{(TIME_W-CNT_W){1'b0}}, cfg.time_limit};

    // Candidate batch after adding the head message
    assign none_enabled  = !cfg.time_en && !cfg.count_en && !cfg.size_en;
    assign byte_sum      = {1'b0, bytes_reg} + {1'b0, head_item.body_bytes};
    assign byte_overflow = cfg.size_en && (byte_sum > {1'b0, cfg.size_limit});
    assign count_one     = cfg.count_en && (cfg.count_limit <= CNT_W'(1));
    assign add_earliest  = (head_item.msg_time < earliest_reg) ? head_item.msg_time
                                                               : earliest_reg;
    assign add_msgs      = (msgs_reg == CNT_MAX) ? CNT_MAX : msgs_reg + CNT_W'(1);
    assign add_bytes     = byte_sum[CNT_W] ? CNT_MAX : byte_sum[CNT_W-1:0];
    assign add_deadline  = add_earliest + tl_ext;
    assign old_deadline  = earliest_reg + tl_ext;
    assign limit_reached = (cfg.time_en && (head_item.now_time >= add_deadline))
                        || (cfg.count_en && (add_msgs >= cfg.count_limit))
                        || (cfg.size_en && (add_bytes >= cfg.size_limit));

    // Decision, in priority order
    always_comb
    begin
        earliest_next = earliest_reg;
        msgs_next     = msgs_reg;
        bytes_next    = bytes_reg;
        action_next   = ACT_LEAVE_MSG_RETURN_BATCH;
        dl_valid_next = 1'b0;
        deadline_next = '0;
        priority if (none_enabled)
        begin
            action_next   = ACT_LEAVE_MSG_RETURN_BATCH;
            dl_valid_next = (msgs_reg != '0) && cfg.time_en;
            deadline_next = dl_valid_next ? old_deadline : '0;
        end
        else if (head_item.oversize)
        begin
            earliest_next = TIME_ALL_ONES;
            msgs_next     = '0;
            bytes_next    = '0;
            action_next   = ACT_LEAVE_MSG_RETURN_BATCH;
        end
        else if (byte_overflow)
        begin
            if (count_one || head_item.msg_aged)
            begin
                earliest_next = TIME_ALL_ONES;
                msgs_next     = '0;
                bytes_next    = '0;
                action_next   = ACT_LEAVE_MSG_RETURN_BATCH;
            end
            else
            begin
                earliest_next = head_item.msg_time;
                msgs_next     = CNT_W'(1);
                bytes_next    = head_item.body_bytes;
                action_next   = ACT_RETURN_BATCH_TAKE_MSG;
                dl_valid_next = cfg.time_en;
                deadline_next = cfg.time_en ? head_item.msg_deadline : '0;
            end
        end
        else if (limit_reached)
        begin
            earliest_next = TIME_ALL_ONES;
            msgs_next     = '0;
            bytes_next    = '0;
            action_next   = ACT_TAKE_MSG_RETURN_BATCH;
        end
        else
        begin
            earliest_next = add_earliest;
            msgs_next     = add_msgs;
            bytes_next    = add_bytes;
            action_next   = ACT_TAKE_MSG_KEEP_BATCH;
            dl_valid_next = cfg.time_en;
            deadline_next = cfg.time_en ? add_deadline : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            earliest_reg  <= TIME_ALL_ONES;
            msgs_reg      <= '0;
            bytes_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                earliest_reg <= earliest_next;
                msgs_reg     <= msgs_next;
                bytes_reg    <= bytes_next;
            end
            if (pop)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            action_reg   <= action_next;
            dl_valid_reg <= dl_valid_next;
            deadline_reg <= deadline_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign action         = action_reg;
    assign deadline_valid = dl_valid_reg;
    assign deadline       = deadline_reg;

endmodule

// File: rtl/message_batch_limit_decider.sv
// Top level of the message batch limit decider: configuration registers and stage wiring.
// Depends on mbld_pkg, mbld_front, mbld_queue and mbld_back.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one message per transaction:
//   now_time, msg_time and body_bytes. Output channel (out_valid / out_stall)
//   returns exactly one result per message: action, deadline_valid, deadline.
//   Configuration channel (cfg_valid / cfg_ready, cfg_index, cfg_data) writes
//   the six limit registers; cfg_ready is always high, indexes above five are
//   dropped. Write configuration only while no message is in flight.
//   Path: the front register loads on acceptance, the queue takes the message
//   from it and the result register is loaded from the queue head.
//   Throughput: one message per cycle while out_stall is low, set by the batch
//   update in the back stage, reading the batch state the previous message left.
//   When out_stall is held the result register holds, the queue fills and
//   in_stall rises once both queue entries and the front register are taken.
//   Reset clears all limits to zero, empties the batch (earliest timestamp
//   all ones, counts zero) and empties every stage.
module message_batch_limit_decider (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    input  logic         in_valid,
    output logic         in_stall,
    input  logic [47:0]  now_time,
    input  logic [47:0]  msg_time,
    input  logic [31:0]  body_bytes,
    output logic         out_valid,
    input  logic         out_stall,
    output logic [1:0]   action,
    output logic         deadline_valid,
    output logic [47:0]  deadline
);
    import mbld_pkg::*;

    cfg_t  cfg_reg;
    logic  cfg_write;
    logic  front_valid;
    item_t front_item;
    logic  queue_full;
    logic  head_valid;
    item_t head_item;
    logic  pop;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_TIME_LIMIT_ENABLE:  cfg_reg.time_en     <= cfg_data[0];
                REG_TIME_LIMIT:         cfg_reg.time_limit  <= cfg_data;
                REG_COUNT_LIMIT_ENABLE: cfg_reg.count_en    <= cfg_data[0];
                REG_COUNT_LIMIT:        cfg_reg.count_limit <= cfg_data;
                REG_SIZE_LIMIT_ENABLE:  cfg_reg.size_en     <= cfg_data[0];
                REG_SIZE_LIMIT:         cfg_reg.size_limit  <= cfg_data;
                default:                cfg_reg             <= cfg_reg;
            endcase
        end
    end

    mbld_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .now_time   (now_time),
        .msg_time   (msg_time),
        .body_bytes (body_bytes),
        .item_valid (front_valid),
        .item       (front_item),
        .queue_full (queue_full)
    );

    mbld_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_item  (front_item),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop)
    );

    mbld_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .head_valid     (head_valid),
        .head_item      (head_item),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .action         (action),
        .deadline_valid (deadline_valid),
        .deadline       (deadline)
    );

endmodule
